// ===== hdl/gcd_lcm_unit_assert.svh =====
// Assertion macros for the gcd_lcm_unit design files, included by glu_engine.
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during rst.
`define GLU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and disabled during rst.
`define GLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GLU_ASSERT_IMPL(lbl, ante, cons, msg)
`define GLU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/glu_pkg.sv =====
// Package with field widths and control types of the GCD and LCM unit.
`timescale 1ns / 1ps
package glu_pkg;

  localparam int OPND_W = 16;
  localparam int GCD_W  = 16;
  localparam int LCM_W  = 32;
  localparam int MAX_W  = 32;

  typedef struct packed {
    logic start;
    logic take;
  } glu_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } glu_stat_t;

endpackage

// ===== hdl/gcd_lcm_unit.sv =====
// Top level of the GCD and LCM unit: request handshake and result register.
// One request at a time; in_ready is high only while the engine is idle.
// A zero operand skips the arithmetic and goes straight to the done state.
// Other requests step through the GCD, shift, division and multiply states, with one
// shared adder for every GCD subtract, division and multiply-add step.
// Reset clears the sequencer and the result valid flag; data registers are not reset.
`timescale 1ns / 1ps
module gcd_lcm_unit import glu_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OPND_W-1:0] operand_a,
  input  logic [OPND_W-1:0] operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GCD_W-1:0]  gcd_value,
  output logic [LCM_W-1:0]  lcm_value,
  output logic              zero_error
);

  localparam int W = OPERAND_WIDTH;

  glu_ctrl_t        ctrl;
  glu_stat_t        stat;
  logic [MAX_W-1:0] a_ext;
  logic [MAX_W-1:0] b_ext;
  logic [W-1:0]     gcd_res;
  logic [2*W-1:0]   lcm_res;
  logic             err_res;
  logic [MAX_W-1:0] g_ext;
  logic [2*MAX_W-1:0] l_ext;

  assign a_ext = MAX_W'(operand_a);
  assign b_ext = MAX_W'(operand_b);
  assign g_ext = MAX_W'(gcd_res);
  assign l_ext = (2*MAX_W)'(lcm_res);

  assign in_ready   = stat.idle;
  assign ctrl.start = in_valid && stat.idle;
  assign ctrl.take  = stat.done && (!out_valid || out_ready);

  glu_engine #(.W(W)) u_engine (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .opnd_a  (a_ext[W-1:0]),
    .opnd_b  (b_ext[W-1:0]),
    .stat    (stat),
    .gcd_res (gcd_res),
    .lcm_res (lcm_res),
    .err_res (err_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      gcd_value  <= g_ext[GCD_W-1:0];
      lcm_value  <= l_ext[LCM_W-1:0];
      zero_error <= err_res;
    end
  end

endmodule

// ===== hdl/glu_addsub.sv =====
// Shared adder and subtractor used by the subtract and add steps of the engine.
`timescale 1ns / 1ps
module glu_addsub #(
  parameter int N = 32
) (
  input  logic [N-1:0] lhs,
  input  logic [N-1:0] rhs,
  input  logic         sub,
  output logic [N-1:0] sum,
  output logic         cout
);

  logic [N:0] total;

  assign total = {1'b0, lhs} + {1'b0, (sub ? ~rhs : rhs)} + (N+1)'(sub);
  assign cout  = total[N];
  assign sum   = total[N-1:0];

endmodule

// ===== hdl/glu_engine.sv =====
// Sequencer and datapath: binary GCD, restoring division and shift-add multiply.
`timescale 1ns / 1ps
`include "gcd_lcm_unit_assert.svh"
module glu_engine import glu_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  glu_ctrl_t    ctrl,
  input  logic [W-1:0] opnd_a,
  input  logic [W-1:0] opnd_b,
  output glu_stat_t    stat,
  output logic [W-1:0] gcd_res,
  output logic [2*W-1:0] lcm_res,
  output logic         err_res
);

  localparam int KW = $clog2(W);
  localparam int UW = 2 * W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GCD   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [W-1:0]  r;
  logic [W-1:0]  q;
  logic [KW-1:0] k;
  logic [KW-1:0] cnt;
  logic [UW-1:0] acc;
  logic [UW-1:0] mcand;
  logic          err;
  logic          in_zero;

  logic [UW-1:0] lhs;
  logic [UW-1:0] rhs;
  logic          sub;
  logic [UW-1:0] sum;
  logic          cout;

  assign in_zero = (opnd_a == '0) || (opnd_b == '0);

  glu_addsub #(.N(UW)) u_addsub (
    .lhs  (lhs),
    .rhs  (rhs),
    .sub  (sub),
    .sum  (sum),
    .cout (cout)
  );

  always_comb begin
    unique case (state)
      S_GCD: begin
        lhs = UW'(x);
        rhs = UW'(y);
        sub = 1'b1;
      end
      S_DIV: begin
        lhs = UW'({r, q[W-1]});
        rhs = UW'(x);
        sub = 1'b1;
      end
      default: begin
        lhs = acc;
        rhs = mcand;
        sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          state_next = in_zero ? S_DONE : S_GCD;
        end
      end
      S_GCD: begin
        if (x == y) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (k == '0) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == KW'(W - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (q[W-1:1] == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (ctrl.take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          x     <= in_zero ? '0 : opnd_a;
          y     <= opnd_b;
          q     <= opnd_a;
          mcand <= UW'(opnd_b);
          r     <= '0;
          k     <= '0;
          cnt   <= '0;
          acc   <= '0;
          err   <= in_zero;
        end
      end
      S_GCD: begin
        if (x != y) begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + KW'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (!cout) begin
            x <= y;
            y <= x;
          end else begin
            x <= sum[W:1];
          end
        end
      end
      S_SHIFT: begin
        if (k != '0) begin
          x <= x << 1;
          k <= k - KW'(1);
        end
      end
      S_DIV: begin
        if (cout) begin
          r <= sum[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= {r[W-2:0], q[W-1]};
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt + KW'(1);
      end
      S_MUL: begin
        if (q[0]) begin
          acc <= sum;
        end
        mcand <= mcand << 1;
        q     <= q >> 1;
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign gcd_res   = x;
  assign lcm_res   = acc;
  assign err_res   = err;

  `GLU_ASSERT_IMPL(a_start_idle, ctrl.start, state == S_IDLE, "Request started while busy.")
  `GLU_ASSERT_IMPL(a_gcd_nonzero, state == S_GCD, x != '0 && y != '0, "GCD operand hit zero.")
  `GLU_ASSERT_IMPL(a_div_rem, state == S_DIV, r < x, "Remainder not below divisor.")
  `GLU_ASSERT_IMPL(a_mul_quot, state == S_MUL, q != '0, "Quotient is zero in multiply.")
  `GLU_ASSERT_NEXT(a_done_hold, state == S_DONE && !ctrl.take, state == S_DONE && $stable(x) && $stable(acc), "Result changed before it was taken.")

endmodule
